FILE: hw/rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types, command codes and start-sequence tables for the two-wire
// sensor interface master.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_BIT_TICKS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_STEP_TICKS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL_TICKS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT          = 2'd3;

    localparam logic [15:0] RST_HALF_BIT_TICKS      = 16'd50;
    localparam logic [15:0] RST_START_STEP_TICKS    = 16'd100;
    localparam logic [23:0] RST_POLL_INTERVAL_TICKS = 24'd20000;
    localparam logic [7:0]  RST_POLL_LIMIT          = 8'd30;

    localparam logic [2:0] CMD_IDLE         = 3'd0;
    localparam logic [2:0] CMD_CONN_RESET   = 3'd1;
    localparam logic [2:0] CMD_SOFT_RESET   = 3'd2;
    localparam logic [2:0] CMD_TEMP         = 3'd3;
    localparam logic [2:0] CMD_HUMI         = 3'd4;
    localparam logic [2:0] CMD_READ_STATUS  = 3'd5;
    localparam logic [2:0] CMD_WRITE_STATUS = 3'd6;

    localparam logic [7:0] CODE_TEMP  = 8'h03;
    localparam logic [7:0] CODE_HUMI  = 8'h05;
    localparam logic [7:0] CODE_RSTAT = 8'h07;
    localparam logic [7:0] CODE_WSTAT = 8'h06;
    localparam logic [7:0] CODE_RESET = 8'h1E;

    // Bit count at which the acknowledge clock of a byte runs
    localparam logic [3:0] ACK_BIT   = 4'd8;
    localparam logic [3:0] START_END = 4'd7;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CRST_HI,
        PH_CRST_LO,
        PH_START,
        PH_WR_LO,
        PH_WR_HI,
        PH_RD_LO,
        PH_RD_HI,
        PH_POLL
    } phase_t;

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [15:0] start_step_ticks;
        logic [23:0] poll_interval_ticks;
        logic [7:0]  poll_limit;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_count;
        logic [1:0]  byte_count;
        logic [7:0]  poll_count;
        logic [7:0]  shift_reg;
        logic [15:0] value_reg;
        logic [7:0]  checksum_reg;
        logic [2:0]  current_command;
        logic [1:0]  error_flags;
    } ctl_t;

    typedef struct packed {
        logic        sck;
        logic        data_drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic [7:0]  checksum;
        logic        no_ack;
        logic        timeout;
    } result_t;

    // Start sequence: per step clock level, data pull-down and length in units
    function automatic logic start_sck(input logic [2:0] step);
        logic [7:0] tbl;
        tbl = 8'b0011_0110;
        return tbl[step];
    endfunction

    function automatic logic start_drv(input logic [2:0] step);
        logic [7:0] tbl;
        tbl = 8'b1001_1100;
        return tbl[step];
    endfunction

    function automatic logic [1:0] start_mul(input logic [2:0] step);
        logic [1:0] m;
        case (step)
            3'd3:    m = 2'd3;
            3'd7:    m = 2'd2;
            default: m = 2'd1;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/tws_if.sv
// ----------------------------------------------------------------------------
// tws_req_if / tws_rsp_if
// Valid/ready channels for tick items into the master and results out of it.
// ----------------------------------------------------------------------------
interface tws_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] write_value;
    logic       data_in;

    modport source (output valid, command, write_value, data_in, input ready);
    modport sink   (input valid, command, write_value, data_in, output ready);
endinterface

interface tws_rsp_if;
    logic        valid;
    logic        ready;
    logic        sck;
    logic        data_drive_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic [7:0]  checksum;
    logic        no_ack;
    logic        timeout;

    modport source (output valid, sck, data_drive_low, busy_res, done_res, read_value,
                    checksum, no_ack, timeout, input ready);
    modport sink   (input valid, sck, data_drive_low, busy_res, done_res, read_value,
                    checksum, no_ack, timeout, output ready);
endinterface

FILE: hw/rtl/tws_step.sv
// ----------------------------------------------------------------------------
// tws_step
// One tick of the bus sequencer: next control state, tick timer and result.
// ----------------------------------------------------------------------------
module tws_step
    import tws_pkg::*;
#(
    parameter int TIMER_WIDTH = 24
) (
    input  cfg_t                   cfg,
    input  ctl_t                   ctl,
    input  logic [TIMER_WIDTH-1:0] tick,
    input  logic [2:0]             command,
    input  logic [7:0]             write_value,
    input  logic                   data_in,
    output ctl_t                   ctl_next,
    output logic [TIMER_WIDTH-1:0] tick_next,
    output result_t                res
);

    localparam int LEN_W = (TIMER_WIDTH > 26) ? TIMER_WIDTH : 26;
    localparam logic [LEN_W-1:0] TMAX = LEN_W'((64'd1 << TIMER_WIDTH) - 64'd1);

    function automatic ctl_t begin_write(input ctl_t c, input logic [7:0] b);
        ctl_t r;
        r           = c;
        r.shift_reg = b;
        r.bit_count = '0;
        r.phase     = PH_WR_LO;
        return r;
    endfunction

    function automatic ctl_t begin_read(input ctl_t c);
        ctl_t r;
        r            = c;
        r.shift_reg  = '0;
        r.bit_count  = '0;
        r.byte_count = c.byte_count + 2'd1;
        r.phase      = PH_RD_LO;
        return r;
    endfunction

    function automatic ctl_t finish(input ctl_t c);
        ctl_t r;
        r            = c;
        r.phase      = PH_IDLE;
        r.bit_count  = '0;
        r.byte_count = '0;
        r.poll_count = '0;
        return r;
    endfunction

    ctl_t             s;
    ctl_t             n;
    logic             done;
    logic             measure;
    logic             acks;
    logic [LEN_W-1:0] len_raw;
    logic [LEN_W-1:0] len;
    logic [LEN_W:0]   tick_inc;
    logic [17:0]      step_x;
    logic [7:0]       lim;
    logic [7:0]       poll_inc;
    logic [7:0]       code;

    always_comb
    begin
        s = ctl;
        if (ctl.phase == PH_IDLE && command inside {[CMD_CONN_RESET:CMD_WRITE_STATUS]})
        begin
            s.current_command = command;
            s.value_reg       = (command == CMD_WRITE_STATUS) ? {8'h00, write_value} : 16'h0;
            s.checksum_reg    = '0;
            s.error_flags     = '0;
            s.bit_count       = '0;
            s.byte_count      = '0;
            s.poll_count      = '0;
            s.shift_reg       = '0;
            s.phase           = (command <= CMD_SOFT_RESET) ? PH_CRST_HI : PH_START;
        end
    end

    assign measure = (s.current_command == CMD_TEMP) || (s.current_command == CMD_HUMI);
    assign acks    = !((s.current_command == CMD_READ_STATUS && s.byte_count == 2'd2) ||
                       (measure && s.byte_count == 2'd3));

    // Segment length, clamped to one tick and to the timer range
    always_comb
    begin
        case (start_mul(s.bit_count[2:0]))
            2'd2:    step_x = {1'b0, cfg.start_step_ticks, 1'b0};
            2'd3:    step_x = {1'b0, cfg.start_step_ticks, 1'b0} + 18'(cfg.start_step_ticks);
            default: step_x = 18'(cfg.start_step_ticks);
        endcase
        case (s.phase)
            PH_CRST_HI, PH_CRST_LO: len_raw = LEN_W'(cfg.start_step_ticks);
            PH_START:               len_raw = LEN_W'(step_x);
            PH_POLL:                len_raw = LEN_W'(cfg.poll_interval_ticks);
            default:                len_raw = LEN_W'(cfg.half_bit_ticks);
        endcase
        if (len_raw == '0)
            len = LEN_W'(1);
        else if (len_raw > TMAX)
            len = TMAX;
        else
            len = len_raw;
    end

    assign tick_inc = (LEN_W+1)'(tick) + (LEN_W+1)'(1);
    assign lim      = (cfg.poll_limit == '0) ? 8'd1 : cfg.poll_limit;
    assign poll_inc = s.poll_count + 8'd1;

    always_comb
    begin
        case (s.current_command)
            CMD_HUMI:         code = CODE_HUMI;
            CMD_READ_STATUS:  code = CODE_RSTAT;
            CMD_WRITE_STATUS: code = CODE_WSTAT;
            default:          code = CODE_TEMP;
        endcase
    end

    // Drive the lines for this tick
    always_comb
    begin
        res                = '0;
        res.busy_res       = (s.phase != PH_IDLE);
        case (s.phase)
            PH_CRST_HI:
                res.sck = 1'b1;
            PH_START:
            begin
                res.sck            = start_sck(s.bit_count[2:0]);
                res.data_drive_low = start_drv(s.bit_count[2:0]);
            end
            PH_WR_LO, PH_WR_HI:
            begin
                res.sck            = (s.phase == PH_WR_HI);
                res.data_drive_low = (s.bit_count < ACK_BIT) ?
                                     !s.shift_reg[~s.bit_count[2:0]] : 1'b0;
            end
            PH_RD_LO, PH_RD_HI:
            begin
                res.sck            = (s.phase == PH_RD_HI);
                res.data_drive_low = (s.bit_count >= ACK_BIT) && acks;
            end
            default:
                res.sck = 1'b0;
        endcase
        res.done_res   = done;
        res.read_value = n.value_reg;
        res.checksum   = n.checksum_reg;
        res.no_ack     = n.error_flags[0];
        res.timeout    = n.error_flags[1];
    end

    // Advance the timer, and the sequence at the end of a segment
    always_comb
    begin
        n         = s;
        done      = 1'b0;
        tick_next = '0;
        if (s.phase != PH_IDLE && tick_inc < (LEN_W+1)'(len))
        begin
            tick_next = TIMER_WIDTH'(tick_inc);
        end
        else if (s.phase != PH_IDLE)
        begin
            case (s.phase)
                PH_CRST_HI:
                    n.phase = PH_CRST_LO;
                PH_CRST_LO:
                    if (s.bit_count >= ACK_BIT)
                    begin
                        if (s.current_command == CMD_SOFT_RESET)
                        begin
                            n.byte_count = '0;
                            n = begin_write(n, CODE_RESET);
                        end
                        else
                        begin
                            n = finish(s);
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        n.bit_count = s.bit_count + 4'd1;
                        n.phase     = PH_CRST_HI;
                    end
                PH_START:
                    if (s.bit_count >= START_END)
                    begin
                        n.byte_count = '0;
                        n = begin_write(n, code);
                    end
                    else
                        n.bit_count = s.bit_count + 4'd1;
                PH_WR_LO:
                    n.phase = PH_WR_HI;
                PH_WR_HI:
                    if (s.bit_count >= ACK_BIT)
                    begin
                        if (data_in)
                            n.error_flags[0] = 1'b1;
                        case (s.current_command)
                            CMD_TEMP, CMD_HUMI:
                                if (data_in)
                                begin
                                    n = finish(n);
                                    done = 1'b1;
                                end
                                else
                                begin
                                    n.phase      = PH_POLL;
                                    n.poll_count = '0;
                                end
                            CMD_READ_STATUS:
                                n = begin_read(n);
                            CMD_WRITE_STATUS:
                                if (s.byte_count == 2'd0)
                                begin
                                    n.byte_count = 2'd1;
                                    n = begin_write(n, s.value_reg[7:0]);
                                end
                                else
                                begin
                                    n = finish(n);
                                    done = 1'b1;
                                end
                            default:
                            begin
                                n = finish(n);
                                done = 1'b1;
                            end
                        endcase
                    end
                    else
                    begin
                        n.bit_count = s.bit_count + 4'd1;
                        n.phase     = PH_WR_LO;
                    end
                PH_RD_LO:
                    n.phase = PH_RD_HI;
                PH_RD_HI:
                    if (s.bit_count >= ACK_BIT)
                    begin
                        if (measure && s.byte_count == 2'd1)
                        begin
                            n.value_reg = {s.shift_reg, 8'h00};
                            n = begin_read(n);
                        end
                        else if (measure && s.byte_count == 2'd2)
                        begin
                            n.value_reg = {s.value_reg[15:8], s.shift_reg};
                            n = begin_read(n);
                        end
                        else if (s.current_command == CMD_READ_STATUS && s.byte_count == 2'd1)
                        begin
                            n.value_reg = {8'h00, s.shift_reg};
                            n = begin_read(n);
                        end
                        else
                        begin
                            if (measure || s.current_command == CMD_READ_STATUS)
                                n.checksum_reg = s.shift_reg;
                            n = finish(n);
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        n.shift_reg = {s.shift_reg[6:0], data_in};
                        n.bit_count = s.bit_count + 4'd1;
                        n.phase     = PH_RD_LO;
                    end
                PH_POLL:
                    if (!data_in)
                    begin
                        n.byte_count = '0;
                        n = begin_read(n);
                    end
                    else
                    begin
                        n.poll_count = poll_inc;
                        if (poll_inc >= lim)
                        begin
                            n.error_flags[1] = 1'b1;
                            n.byte_count     = '0;
                            n = begin_read(n);
                        end
                    end
                default:
                begin
                    n = finish(s);
                    done = 1'b1;
                end
            endcase
        end
    end

    assign ctl_next = n;

endmodule

FILE: hw/rtl/two_wire_sensor_interface_core.sv
// ----------------------------------------------------------------------------
// two_wire_sensor_interface_core
// Bus master for a two-wire humidity/temperature sensor, advanced one tick
// per request item.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------------
//  req     | in  | valid/ready | command[2:0], write_value[7:0], data_in
//  rsp     | out | valid/ready | sck, data_drive_low, busy_res, done_res,
//          |     |             | read_value[15:0], checksum[7:0], no_ack, timeout
//  cfg     | in  | cfg_we      | cfg_index[1:0], cfg_data[23:0]
//
//  One request item is taken per cycle while req.ready is high; its result is
//  registered and shows on rsp in the next cycle.
//  Reset clears the sequencer to idle and loads the timing registers with
//  their defaults (50, 100, 20000, 30).
//  req.ready falls only while a result is held and rsp.ready is low; the
//  sequencer does not advance without an accepted item.
//
module two_wire_sensor_interface_core
    import tws_pkg::*;
#(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    tws_req_if.sink                req,
    tws_rsp_if.source              rsp
);

    cfg_t                   cfg_reg;
    ctl_t                   ctl_reg;
    ctl_t                   ctl_next;
    logic [TIMER_WIDTH-1:0] tick_reg;
    logic [TIMER_WIDTH-1:0] tick_next;
    result_t                res_next;
    result_t                res_reg;
    logic                   rsp_valid_reg;
    logic                   accept;

    // Take a new item whenever the result slot is empty or being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Timing registers; the user must write them only while the sequencer is idle (the block does no check)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks      <= RST_HALF_BIT_TICKS;
            cfg_reg.start_step_ticks    <= RST_START_STEP_TICKS;
            cfg_reg.poll_interval_ticks <= RST_POLL_INTERVAL_TICKS;
            cfg_reg.poll_limit          <= RST_POLL_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_BIT_TICKS:      cfg_reg.half_bit_ticks      <= cfg_data[15:0];
                CFG_START_STEP_TICKS:    cfg_reg.start_step_ticks    <= cfg_data[15:0];
                CFG_POLL_INTERVAL_TICKS: cfg_reg.poll_interval_ticks <= cfg_data;
                CFG_POLL_LIMIT:          cfg_reg.poll_limit          <= cfg_data[7:0];
                default:                 cfg_reg.poll_limit          <= cfg_reg.poll_limit;
            endcase
        end
    end

    // Sequencer step: all of one tick's work between state and result register
    tws_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .cfg         (cfg_reg),
        .ctl         (ctl_reg),
        .tick        (tick_reg),
        .command     (req.command),
        .write_value (req.write_value),
        .data_in     (req.data_in),
        .ctl_next    (ctl_next),
        .tick_next   (tick_next),
        .res         (res_next)
    );

    // Advance the sequencer only on an accepted item; all-zero state is idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            tick_reg <= '0;
        end
        else if (accept)
        begin
            ctl_reg  <= ctl_next;
            tick_reg <= tick_next;
        end
    end

    // Result slot: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.sck            = res_reg.sck;
    assign rsp.data_drive_low = res_reg.data_drive_low;
    assign rsp.busy_res       = res_reg.busy_res;
    assign rsp.done_res       = res_reg.done_res;
    assign rsp.read_value     = res_reg.read_value;
    assign rsp.checksum       = res_reg.checksum;
    assign rsp.no_ack         = res_reg.no_ack;
    assign rsp.timeout        = res_reg.timeout;

    // A completing tick always belongs to a running sequence
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && res_reg.done_res |-> res_reg.busy_res)
        else $error("done without busy");

    // The timer is parked at zero while idle
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.phase == PH_IDLE |-> tick_reg == '0)
        else $error("tick count running while idle");

    // Bit counter never passes the acknowledge clock
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.bit_count <= ACK_BIT)
        else $error("bit count out of range");

    // Polling only follows an acknowledged measurement command
    a_poll_measure: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.phase == PH_POLL |->
            (ctl_reg.current_command == CMD_TEMP || ctl_reg.current_command == CMD_HUMI)
            && !ctl_reg.error_flags[0])
        else $error("poll outside a measurement");

endmodule
